/* design/assert_macros.svh */
// assertion macros used by the design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// antecedent implies consequent on the following clock edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/ptma_pkg.sv */
// types and constants of the polynomial term merge add unit
package ptma_pkg;

   localparam int OP_W    = 2;
   localparam int COEFF_W = 16;
   localparam int POWER_W = 16;
   localparam int SUM_W   = 17;
   localparam int TERM_W  = COEFF_W + POWER_W;

   localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
   localparam logic [OP_W-1:0] OP_MERGE    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

/* design/polynomial_term_merge_add_unit.sv */
// polynomial term merge add unit: two term stores and a merge sequencer
//
// req channel carries one command per transfer: op 0 appends (coeff, power)
// to list A, op 1 appends to list B, op 2 merges both lists onto rsp.
// an append to a full list is dropped; an op of 3 is ignored.
// appends are taken one per cycle; req_stall is low whenever no merge runs.
// a merge holds req_stall high until its final term sits in the rsp register.
// each result term passes ST_READ, for the registered read of both term
// memories, then ST_EMIT, for the shared power compare and coefficient add
// into the rsp register. a merge of two empty lists gives no result. the
// final term carries rsp_last and both lists are then emptied.
// rsp is one output register; while rsp_valid and rsp_stall are both high the
// sequencer waits with the next term and the register holds its contents.
// reset empties both lists and clears rsp_valid; the term memories keep
// whatever they held, and entries are only read after being written.
`include "assert_macros.svh"

module polynomial_term_merge_add_unit #(
   parameter int MAX_TERMS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic        [ptma_pkg::OP_W-1:0]       req_op,
   input  logic signed [ptma_pkg::COEFF_W-1:0]    req_coeff,
   input  logic        [ptma_pkg::POWER_W-1:0]    req_power,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ptma_pkg::SUM_W-1:0]      rsp_sum_coeff,
   output logic        [ptma_pkg::POWER_W-1:0]    rsp_sum_power,
   output logic                                   rsp_last
);
   import ptma_pkg::*;

   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   logic [TERM_W-1:0] terms_a [MAX_TERMS];
   logic [TERM_W-1:0] terms_b [MAX_TERMS];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_a_ff, count_a_in;
   logic [CNT_W-1:0]  count_b_ff, count_b_in;
   logic [CNT_W-1:0]  ia_ff, ia_in;
   logic [CNT_W-1:0]  ib_ff, ib_in;
   logic [TERM_W-1:0] rd_a_ff, rd_b_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0]  rsp_coeff_ff, rsp_coeff_in;
   logic [POWER_W-1:0]       rsp_power_ff, rsp_power_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     req_xfer;
   logic                     wr_a, wr_b;
   logic [TERM_W-1:0]        entry;
   logic                     a_left, b_left, out_free, done;
   logic signed [COEFF_W-1:0] ca, cb;
   logic [POWER_W-1:0]       pa, pb;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign entry     = {req_coeff, req_power};
   assign wr_a      = req_xfer && (req_op == OP_APPEND_A) && (count_a_ff < CNT_MAX);
   assign wr_b      = req_xfer && (req_op == OP_APPEND_B) && (count_b_ff < CNT_MAX);

   assign ca = rd_a_ff[TERM_W-1 -: COEFF_W];
   assign cb = rd_b_ff[TERM_W-1 -: COEFF_W];
   assign pa = rd_a_ff[POWER_W-1:0];
   assign pb = rd_b_ff[POWER_W-1:0];

   assign a_left   = (ia_ff < count_a_ff);
   assign b_left   = (ib_ff < count_b_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // term memories
   always_ff @(posedge clock) begin
      if (wr_a) begin
         terms_a[count_a_ff[IDX_W-1:0]] <= entry;
      end
      if (wr_b) begin
         terms_b[count_b_ff[IDX_W-1:0]] <= entry;
      end
      rd_a_ff <= terms_a[ia_ff[IDX_W-1:0]];
      rd_b_ff <= terms_b[ib_ff[IDX_W-1:0]];
   end

   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      done         = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_coeff_in = rsp_coeff_ff;
      rsp_power_in = rsp_power_ff;
      rsp_last_in  = rsp_last_ff;
      if (wr_a) begin
         count_a_in = count_a_ff + CNT_ONE;
      end
      if (wr_b) begin
         count_b_in = count_b_ff + CNT_ONE;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_op == OP_MERGE)) begin
               ia_in = '0;
               ib_in = '0;
               if ((count_a_ff != '0) || (count_b_ff != '0)) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (a_left && b_left && (pa == pb)) begin
               rsp_coeff_in = SUM_W'(ca) + SUM_W'(cb);
               rsp_power_in = pa;
               ia_in        = ia_ff + CNT_ONE;
               ib_in        = ib_ff + CNT_ONE;
            end else if (a_left && (!b_left || (pa > pb))) begin
               rsp_coeff_in = SUM_W'(ca);
               rsp_power_in = pa;
               ia_in        = ia_ff + CNT_ONE;
            end else begin
               rsp_coeff_in = SUM_W'(cb);
               rsp_power_in = pb;
               ib_in        = ib_ff + CNT_ONE;
            end
            done        = (ia_in >= count_a_ff) && (ib_in >= count_b_ff);
            rsp_last_in = done;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (done) begin
                  state_in   = ST_IDLE;
                  count_a_in = '0;
                  count_b_in = '0;
               end else begin
                  state_in = ST_READ;
               end
            end else begin
               ia_in        = ia_ff;
               ib_in        = ib_ff;
               rsp_coeff_in = rsp_coeff_ff;
               rsp_power_in = rsp_power_ff;
               rsp_last_in  = rsp_last_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_coeff_ff <= rsp_coeff_in;
      rsp_power_ff <= rsp_power_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum_coeff = rsp_coeff_ff;
   assign rsp_sum_power = rsp_power_ff;
   assign rsp_last      = rsp_last_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, (count_a_ff <= CNT_MAX) && (count_b_ff <= CNT_MAX))
   `ASSERT_ALWAYS(a_emit_has_term, clock, reset, (state_ff != ST_EMIT) || a_left || b_left)
   `ASSERT_NEXT(a_read_then_emit, clock, reset, state_ff == ST_READ, state_ff == ST_EMIT)

endmodule

/* tb/tb_top.sv */
// testbench for the polynomial term merge add unit: queued stimulus, term-list merge predictor
`timescale 1ns / 100ps

module tb_top;
   import ptma_pkg::*;

   localparam int TERM_SLOTS = 32;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [COEFF_W-1:0] coeff;
      logic [POWER_W-1:0] power;
      int                 gap;
   } command_type;

   typedef struct {
      logic signed [SUM_W-1:0] sum_coeff;
      logic [POWER_W-1:0]      sum_power;
      logic                    last;
   } result_term_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OP_W-1:0]           req_op = '0;
   logic signed [COEFF_W-1:0] req_coeff = '0;
   logic [POWER_W-1:0]        req_power = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [SUM_W-1:0]   rsp_sum_coeff;
   logic [POWER_W-1:0]        rsp_sum_power;
   logic                      rsp_last;

   command_type     pending_commands[$];
   result_term_type merged_terms_q[$];

   logic signed [COEFF_W-1:0] coeff_a[TERM_SLOTS];
   logic [POWER_W-1:0]        power_a[TERM_SLOTS];
   logic signed [COEFF_W-1:0] coeff_b[TERM_SLOTS];
   logic [POWER_W-1:0]        power_b[TERM_SLOTS];
   int count_a = 0;
   int count_b = 0;

   int  fail_count = 0;
   int  rsp_count = 0;
   int  random_items = 0;
   bit  counting_random = 1'b0;
   bit  idle_enabled = 1'b0;
   bit  req_accepted = 1'b0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   polynomial_term_merge_add_unit #(.MAX_TERMS(TERM_SLOTS)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_coeff     (req_coeff),
      .req_power     (req_power),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sum_coeff (rsp_sum_coeff),
      .rsp_sum_power (rsp_sum_power),
      .rsp_last      (rsp_last)
   );

   always #2 clock = ~clock;

   function automatic int pick_delay(input int long_max);
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, long_max);
   endfunction

   function automatic logic [COEFF_W-1:0] random_coeff();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 16'h7fff;
      if (r == 1) return 16'h8000;
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic queue_command(input logic [OP_W-1:0] op, input logic [COEFF_W-1:0] coeff,
                                input logic [POWER_W-1:0] power);
      command_type c;
      c.op = op;
      c.coeff = coeff;
      c.power = power;
      c.gap = idle_enabled ? pick_delay(30) : 0;
      pending_commands.push_back(c);
      if (counting_random && op != OP_UNUSED) random_items++;
   endtask

   // two term lists followed by a merge; sorted lists share some powers
   task automatic queue_polynomial_pair(input int na, input int nb, input bit sorted);
      int ca;
      int cb;
      int p;
      int gap;
      int sel;
      ca = 0;
      cb = 0;
      p = $urandom_range(0, 65535);
      while (ca < na || cb < nb) begin
         if (ca >= na) sel = 1;
         else if (cb >= nb) sel = 0;
         else sel = $urandom_range(0, 2);
         if (!sorted) p = $urandom_range(0, 65535);
         if (sel != 1) begin
            queue_command(OP_APPEND_A, random_coeff(), 16'(p));
            ca++;
         end
         if (sel != 0) begin
            queue_command(OP_APPEND_B, random_coeff(), 16'(p));
            cb++;
         end
         if (sorted) begin
            gap = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 2000);
            p = (p > gap) ? p - gap : 0;
         end
         if ($urandom_range(0, 19) == 0)
            queue_command(OP_UNUSED, random_coeff(), 16'($urandom_range(0, 65535)));
      end
      queue_command(OP_MERGE, random_coeff(), 16'($urandom_range(0, 65535)));
   endtask

   task automatic apply_command(input logic [OP_W-1:0] op, input logic signed [COEFF_W-1:0] coeff,
                                input logic [POWER_W-1:0] power);
      int ia;
      int ib;
      result_term_type t;
      case (op)
         OP_APPEND_A: begin
            if (count_a < TERM_SLOTS) begin
               coeff_a[count_a] = coeff;
               power_a[count_a] = power;
               count_a++;
            end
         end
         OP_APPEND_B: begin
            if (count_b < TERM_SLOTS) begin
               coeff_b[count_b] = coeff;
               power_b[count_b] = power;
               count_b++;
            end
         end
         OP_MERGE: begin
            ia = 0;
            ib = 0;
            while (ia < count_a || ib < count_b) begin
               if (ia < count_a && ib < count_b && power_a[ia] == power_b[ib]) begin
                  t.sum_coeff = {coeff_a[ia][COEFF_W-1], coeff_a[ia]}
                              + {coeff_b[ib][COEFF_W-1], coeff_b[ib]};
                  t.sum_power = power_a[ia];
                  ia++;
                  ib++;
               end else if (ib >= count_b || (ia < count_a && power_a[ia] > power_b[ib])) begin
                  t.sum_coeff = {coeff_a[ia][COEFF_W-1], coeff_a[ia]};
                  t.sum_power = power_a[ia];
                  ia++;
               end else begin
                  t.sum_coeff = {coeff_b[ib][COEFF_W-1], coeff_b[ib]};
                  t.sum_power = power_b[ib];
                  ib++;
               end
               t.last = (ia >= count_a && ib >= count_b);
               merged_terms_q.push_back(t);
            end
            count_a = 0;
            count_b = 0;
         end
         default: ;
      endcase
   endtask

   // sender
   always @(negedge clock) begin
      command_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_commands.size() != 0) begin
            c = pending_commands.pop_front();
            req_op <= c.op;
            req_coeff <= c.coeff;
            req_power <= c.power;
            req_valid <= 1'b1;
            gap_left = c.gap;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off in the middle of a merge
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && rsp_count >= 10 && rsp_valid) begin
         hold_done = 1'b1;
         hold_left = 120;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = ((rsp_count / 32) % 3 == 0) ? 0 : pick_delay(25);
      end
   end

   // transfer monitor and result check
   always @(posedge clock) begin
      result_term_type exp_term;
      if (reset) begin
         req_accepted = 1'b0;
      end else begin
         req_accepted = req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (merged_terms_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: coeff %0d power %0d last %0b",
                           rsp_sum_coeff, rsp_sum_power, rsp_last);
            end else begin
               exp_term = merged_terms_q.pop_front();
               if (rsp_sum_coeff !== exp_term.sum_coeff || rsp_sum_power !== exp_term.sum_power
                   || rsp_last !== exp_term.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result %0d: expected coeff %0d power %0d last %0b, got %0d %0d %0b",
                              rsp_count, exp_term.sum_coeff, exp_term.sum_power, exp_term.last,
                              rsp_sum_coeff, rsp_sum_power, rsp_last);
               end
            end
         end
         if (req_accepted) apply_command(req_op, req_coeff, req_power);
      end
   end

   initial begin : stimulus
      int na;
      int nb;
      // empty merge and unused op
      queue_command(OP_MERGE, 16'h0000, 16'h0000);
      queue_command(OP_UNUSED, 16'hffff, 16'hffff);
      // extreme coefficients, extreme powers, zero sum
      queue_command(OP_APPEND_A, 16'h7fff, 16'hffff);
      queue_command(OP_APPEND_A, 16'h8000, 16'd100);
      queue_command(OP_APPEND_A, 16'h0001, 16'h0000);
      queue_command(OP_APPEND_B, 16'h7fff, 16'hffff);
      queue_command(OP_APPEND_B, 16'h8000, 16'd100);
      queue_command(OP_APPEND_B, 16'hffff, 16'h0000);
      queue_command(OP_MERGE, 16'h0000, 16'h0000);
      // one list empty
      queue_command(OP_APPEND_A, 16'd5, 16'd7);
      queue_command(OP_MERGE, 16'h0000, 16'h0000);
      queue_command(OP_APPEND_B, -16'sd5, 16'd9);
      queue_command(OP_APPEND_B, 16'd3, 16'd2);
      queue_command(OP_MERGE, 16'h0000, 16'h0000);
      // unsorted lists
      queue_command(OP_APPEND_A, 16'd1, 16'd3);
      queue_command(OP_APPEND_A, 16'd2, 16'd10);
      queue_command(OP_APPEND_B, 16'd4, 16'd5);
      queue_command(OP_MERGE, 16'h0000, 16'h0000);

      counting_random = 1'b1;
      idle_enabled = 1'b1;
      // both lists overfilled
      queue_polynomial_pair(34, 34, 1'b1);
      while (random_items < 82) begin
         idle_enabled = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 19) == 0) begin
            na = $urandom_range(28, 34);
            nb = $urandom_range(0, 34);
         end else begin
            na = $urandom_range(0, 6);
            nb = $urandom_range(0, 6);
         end
         queue_polynomial_pair(na, nb, $urandom_range(0, 99) < 85);
      end

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      while (pending_commands.size() != 0 || req_valid) @(posedge clock);
      while (merged_terms_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule
